>>> src/packet_ring_capture_tracker_unit_macros.svh
// Assertion macros for the packet ring capture tracker checker
`ifndef PACKET_RING_CAPTURE_TRACKER_UNIT_MACROS_SVH
`define PACKET_RING_CAPTURE_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRCT_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PRCT_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/prct_pkg.sv
// Shared types and constants for the packet ring capture tracker
`timescale 1ns / 1ps

package prct_pkg;

    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 5;
    localparam int LIMIT_W      = 26;
    localparam int ENTRIES_W    = 17;
    localparam int EXTRA_W      = 6;
    localparam int KIND_W       = 2;
    localparam int COUNTER_W    = 16;
    localparam int LOOP_W       = 16;
    localparam int TOTAL_W      = 32;
    localparam int BYTES_LOW_W  = 30;
    localparam int BYTES_HIGH_W = 16;
    localparam int TAIL_W       = 64;

    localparam logic [2:0] REG_GAP_EN      = 3'd0;
    localparam logic [2:0] REG_EEV_EN      = 3'd1;
    localparam logic [2:0] REG_TRAILER     = 3'd2;
    localparam logic [2:0] REG_LEN_EXTRA   = 3'd3;
    localparam logic [2:0] REG_BUF_LIMIT   = 3'd4;
    localparam logic [2:0] REG_EEV_LIMIT   = 3'd5;
    localparam logic [2:0] REG_RING_ENTRIES = 3'd6;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [KIND_W-1:0] TRAILER_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] TRAILER_UNIQUE = 2'd1;
    localparam logic [KIND_W-1:0] TRAILER_NIBBLE = 2'd2;

    localparam logic [BYTES_LOW_W:0]  BILLION     = 31'd1000000000;
    localparam logic [LOOP_W-1:0]     STATUS_GAP  = 16'h8000;
    localparam logic [LOOP_W-1:0]     STATUS_EEV  = 16'h4000;
    localparam logic [15:0]           WORD_MARK   = 16'h8000;
    localparam logic [15:0]           WORD_ONES   = 16'hffff;
    localparam logic [3:0]            NIBBLE_F    = 4'hf;
    localparam logic [3:0]            NIBBLE_E    = 4'he;
    localparam int                    SHORT_LEN   = 64;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 26'h3ffffff;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 17'h10000;

    typedef struct packed {
        logic                 gap_en;
        logic                 eev_en;
        logic [KIND_W-1:0]    trailer_kind;
        logic [EXTRA_W-1:0]   length_extra;
        logic [LIMIT_W-1:0]   buffer_limit;
        logic [LIMIT_W-1:0]   event_limit;
        logic [ENTRIES_W-1:0] ring_entries;
    } cfg_t;

endpackage

>>> src/packet_ring_capture_tracker_unit.sv
// Packet ring capture tracker: top level with input and result registers
//
// Input channel (in_valid / in_stall): one transaction per packet descriptor
// or clear command. Result channel (out_valid / out_stall): one ring entry
// descriptor per packet; a clear command produces no result and zeroes all
// pointers and totals.
// Path: a packet is captured in the input register, and its result is then
// loaded into the result register, which drives the result port.
// Throughput: one transaction per cycle unless a held result is stalled;
// the tracker computes each result combinationally between the two registers.
// When out_stall is high with a result held, the input register holds its
// packet and in_stall rises; a pending clear still completes.
// The user writes configuration over APB (byte address 4*index) only while idle; the block does not enforce it.
// Reset: all pointers, counters and totals clear; registers take their
// defaults (checks enabled, no trailer test, limits and ring size at max).
`timescale 1ns / 1ps

module packet_ring_capture_tracker_unit #(
    parameter int BUFFER_ADDR_BITS = 26,
    parameter int RING_INDEX_BITS  = 16,
    parameter int LENGTH_BITS      = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prct_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [prct_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [prct_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [LENGTH_BITS-1:0]              packet_length,
    input  logic [prct_pkg::COUNTER_W-1:0]      packet_counter,
    input  logic [prct_pkg::TAIL_W-1:0]         tail_words_a,
    input  logic [prct_pkg::TAIL_W-1:0]         tail_words_b,
    input  logic [prct_pkg::TAIL_W-1:0]         tail_words_c,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [prct_pkg::LOOP_W-1:0]         entry_status,
    output logic [RING_INDEX_BITS-1:0]          entry_index,
    output logic [LENGTH_BITS:0]                entry_length,
    output logic [BUFFER_ADDR_BITS-1:0]         data_offset,
    output logic [BUFFER_ADDR_BITS-1:0]         next_offset,
    output logic [prct_pkg::TOTAL_W-1:0]        missing_total,
    output logic [prct_pkg::TOTAL_W-1:0]        packets_total,
    output logic [prct_pkg::BYTES_LOW_W-1:0]    bytes_low,
    output logic [prct_pkg::BYTES_HIGH_W-1:0]   bytes_high
);

    prct_pkg::cfg_t cfg;

    logic                               in_vld_reg;
    logic                               cmd_reg;
    logic [LENGTH_BITS-1:0]             len_reg;
    logic [prct_pkg::COUNTER_W-1:0]     cnt_reg;
    logic [prct_pkg::TAIL_W-1:0]        tail_a_reg;
    logic [prct_pkg::TAIL_W-1:0]        tail_b_reg;
    logic [prct_pkg::TAIL_W-1:0]        tail_c_reg;

    logic                               out_vld_reg;
    logic [prct_pkg::LOOP_W-1:0]        status_reg;
    logic [RING_INDEX_BITS-1:0]         index_reg;
    logic [LENGTH_BITS:0]               length_reg;
    logic [BUFFER_ADDR_BITS-1:0]        offset_reg;
    logic [BUFFER_ADDR_BITS-1:0]        next_off_reg;
    logic [prct_pkg::TOTAL_W-1:0]       missing_reg;
    logic [prct_pkg::TOTAL_W-1:0]       packets_reg;
    logic [prct_pkg::BYTES_LOW_W-1:0]   blow_reg;
    logic [prct_pkg::BYTES_HIGH_W-1:0]  bhigh_reg;

    logic                               out_room;
    logic                               consume;
    logic                               pkt_en;
    logic                               clr_en;
    logic                               in_fire;

    logic [prct_pkg::LOOP_W-1:0]        res_status;
    logic [RING_INDEX_BITS-1:0]         res_index;
    logic [LENGTH_BITS:0]               res_length;
    logic [BUFFER_ADDR_BITS-1:0]        res_offset;
    logic [BUFFER_ADDR_BITS-1:0]        res_next_offset;
    logic [prct_pkg::TOTAL_W-1:0]       res_missing;
    logic [prct_pkg::TOTAL_W-1:0]       res_packets;
    logic [prct_pkg::BYTES_LOW_W-1:0]   res_bytes_low;
    logic [prct_pkg::BYTES_HIGH_W-1:0]  res_bytes_high;

    prct_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_room = ~out_vld_reg | ~out_stall;
    assign consume  = in_vld_reg & ((cmd_reg == prct_pkg::CMD_CLEAR) | out_room);
    assign clr_en   = consume & (cmd_reg == prct_pkg::CMD_CLEAR);
    assign pkt_en   = consume & (cmd_reg == prct_pkg::CMD_PACKET);
    assign in_stall = in_vld_reg & ~consume;
    assign in_fire  = in_valid & ~in_stall;

    prct_track #(
        .BUFFER_ADDR_BITS (BUFFER_ADDR_BITS),
        .RING_INDEX_BITS  (RING_INDEX_BITS),
        .LENGTH_BITS      (LENGTH_BITS)
    ) u_track (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .pkt_en          (pkt_en),
        .clr_en          (clr_en),
        .pkt_length      (len_reg),
        .pkt_counter     (cnt_reg),
        .tail_a          (tail_a_reg),
        .tail_b          (tail_b_reg),
        .tail_c          (tail_c_reg),
        .res_status      (res_status),
        .res_index       (res_index),
        .res_length      (res_length),
        .res_offset      (res_offset),
        .res_next_offset (res_next_offset),
        .res_missing     (res_missing),
        .res_packets     (res_packets),
        .res_bytes_low   (res_bytes_low),
        .res_bytes_high  (res_bytes_high)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                in_vld_reg <= 1'b1;
            else if (consume)
                in_vld_reg <= 1'b0;

            if (pkt_en)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= command;
            len_reg    <= packet_length;
            cnt_reg    <= packet_counter;
            tail_a_reg <= tail_words_a;
            tail_b_reg <= tail_words_b;
            tail_c_reg <= tail_words_c;
        end
        if (pkt_en)
        begin
            status_reg   <= res_status;
            index_reg    <= res_index;
            length_reg   <= res_length;
            offset_reg   <= res_offset;
            next_off_reg <= res_next_offset;
            missing_reg  <= res_missing;
            packets_reg  <= res_packets;
            blow_reg     <= res_bytes_low;
            bhigh_reg    <= res_bytes_high;
        end
    end

    assign out_valid     = out_vld_reg;
    assign entry_status  = status_reg;
    assign entry_index   = index_reg;
    assign entry_length  = length_reg;
    assign data_offset   = offset_reg;
    assign next_offset   = next_off_reg;
    assign missing_total = missing_reg;
    assign packets_total = packets_reg;
    assign bytes_low     = blow_reg;
    assign bytes_high    = bhigh_reg;

endmodule

>>> src/prct_regs.sv
// APB configuration registers for the packet ring capture tracker
`timescale 1ns / 1ps

module prct_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prct_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [prct_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [prct_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output prct_pkg::cfg_t                      cfg
);

    prct_pkg::cfg_t cfg_reg;
    prct_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[prct_pkg::CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                prct_pkg::REG_GAP_EN:       cfg_next.gap_en = pwdata[0];
                prct_pkg::REG_EEV_EN:       cfg_next.eev_en = pwdata[0];
                prct_pkg::REG_TRAILER:
                    cfg_next.trailer_kind = pwdata[prct_pkg::KIND_W-1:0];
                prct_pkg::REG_LEN_EXTRA:
                    cfg_next.length_extra = pwdata[prct_pkg::EXTRA_W-1:0];
                prct_pkg::REG_BUF_LIMIT:
                    cfg_next.buffer_limit = pwdata[prct_pkg::LIMIT_W-1:0];
                prct_pkg::REG_EEV_LIMIT:
                    cfg_next.event_limit = pwdata[prct_pkg::LIMIT_W-1:0];
                prct_pkg::REG_RING_ENTRIES:
                    cfg_next.ring_entries = pwdata[prct_pkg::ENTRIES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_en       <= 1'b1;
            cfg_reg.eev_en       <= 1'b1;
            cfg_reg.trailer_kind <= prct_pkg::TRAILER_NONE;
            cfg_reg.length_extra <= '0;
            cfg_reg.buffer_limit <= prct_pkg::LIMIT_RESET;
            cfg_reg.event_limit  <= prct_pkg::LIMIT_RESET;
            cfg_reg.ring_entries <= prct_pkg::ENTRIES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            prct_pkg::REG_GAP_EN:       prdata[0] = cfg_reg.gap_en;
            prct_pkg::REG_EEV_EN:       prdata[0] = cfg_reg.eev_en;
            prct_pkg::REG_TRAILER:
                prdata[prct_pkg::KIND_W-1:0] = cfg_reg.trailer_kind;
            prct_pkg::REG_LEN_EXTRA:
                prdata[prct_pkg::EXTRA_W-1:0] = cfg_reg.length_extra;
            prct_pkg::REG_BUF_LIMIT:
                prdata[prct_pkg::LIMIT_W-1:0] = cfg_reg.buffer_limit;
            prct_pkg::REG_EEV_LIMIT:
                prdata[prct_pkg::LIMIT_W-1:0] = cfg_reg.event_limit;
            prct_pkg::REG_RING_ENTRIES:
                prdata[prct_pkg::ENTRIES_W-1:0] = cfg_reg.ring_entries;
            default:                    prdata = '0;
        endcase
    end

endmodule

>>> src/prct_track.sv
// Tracker state and per-packet update logic
`timescale 1ns / 1ps

module prct_track #(
    parameter int BUFFER_ADDR_BITS = 26,
    parameter int RING_INDEX_BITS  = 16,
    parameter int LENGTH_BITS      = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  prct_pkg::cfg_t                      cfg,
    input  logic                                pkt_en,
    input  logic                                clr_en,
    input  logic [LENGTH_BITS-1:0]              pkt_length,
    input  logic [prct_pkg::COUNTER_W-1:0]      pkt_counter,
    input  logic [prct_pkg::TAIL_W-1:0]         tail_a,
    input  logic [prct_pkg::TAIL_W-1:0]         tail_b,
    input  logic [prct_pkg::TAIL_W-1:0]         tail_c,
    output logic [prct_pkg::LOOP_W-1:0]         res_status,
    output logic [RING_INDEX_BITS-1:0]          res_index,
    output logic [LENGTH_BITS:0]                res_length,
    output logic [BUFFER_ADDR_BITS-1:0]         res_offset,
    output logic [BUFFER_ADDR_BITS-1:0]         res_next_offset,
    output logic [prct_pkg::TOTAL_W-1:0]        res_missing,
    output logic [prct_pkg::TOTAL_W-1:0]        res_packets,
    output logic [prct_pkg::BYTES_LOW_W-1:0]    res_bytes_low,
    output logic [prct_pkg::BYTES_HIGH_W-1:0]   res_bytes_high
);

    localparam int LEN_W   = LENGTH_BITS + 1;
    localparam int SUM_W   = ((BUFFER_ADDR_BITS > LEN_W) ? BUFFER_ADDR_BITS : LEN_W) + 1;
    localparam int CMP_W   = (SUM_W > prct_pkg::LIMIT_W) ? SUM_W : prct_pkg::LIMIT_W;
    localparam int IDX1_W  = RING_INDEX_BITS + 1;
    localparam int ICMP_W  = (IDX1_W > prct_pkg::ENTRIES_W) ? IDX1_W : prct_pkg::ENTRIES_W;
    localparam int BSUM_W  = prct_pkg::BYTES_LOW_W + 1;

    logic [BUFFER_ADDR_BITS-1:0]         offset_reg,   offset_next;
    logic [RING_INDEX_BITS-1:0]          index_reg,    index_next;
    logic [prct_pkg::LOOP_W-1:0]         loop_reg,     loop_next;
    logic [prct_pkg::COUNTER_W-1:0]      last_reg,     last_next;
    logic [prct_pkg::TOTAL_W-1:0]        gaps_reg,     gaps_next;
    logic [prct_pkg::TOTAL_W-1:0]        pkts_reg,     pkts_next;
    logic [prct_pkg::BYTES_LOW_W-1:0]    blow_reg,     blow_next;
    logic [prct_pkg::BYTES_HIGH_W-1:0]   bhigh_reg,    bhigh_next;

    logic [LEN_W-1:0]    len;
    logic [BSUM_W-1:0]   byte_sum;
    logic                byte_carry;
    logic                gap;
    logic                eev;
    logic                trailer_hit;
    logic [SUM_W-1:0]    off_sum;
    logic [CMP_W-1:0]    off_cmp;
    logic [IDX1_W-1:0]   idx_inc;
    logic                wrap;

    function automatic logic match_trailer(
        input logic [prct_pkg::KIND_W-1:0] kind,
        input logic [prct_pkg::TAIL_W-1:0] a,
        input logic [prct_pkg::TAIL_W-1:0] b,
        input logic [prct_pkg::TAIL_W-1:0] c
    );
        logic hit;
        hit = 1'b0;
        case (kind)
            prct_pkg::TRAILER_UNIQUE:
                hit = (a[15:0]  == prct_pkg::WORD_MARK) && (a[31:16] == prct_pkg::WORD_MARK) &&
                      (a[47:32] == prct_pkg::WORD_ONES) && (a[63:48] == prct_pkg::WORD_MARK);
            prct_pkg::TRAILER_NIBBLE:
            begin
                hit = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    if (b[16*k+12 +: 4] != prct_pkg::NIBBLE_F)
                        hit = 1'b0;
                    if (c[16*k+12 +: 4] != prct_pkg::NIBBLE_E)
                        hit = 1'b0;
                end
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    always_comb
    begin
        len        = LEN_W'(pkt_length) + LEN_W'(cfg.length_extra);
        byte_sum   = {1'b0, blow_reg} + BSUM_W'(len);
        byte_carry = byte_sum > prct_pkg::BILLION;

        gap = cfg.gap_en && (prct_pkg::COUNTER_W'(last_reg + 1'b1) != pkt_counter) &&
              ((index_reg != '0) || (loop_reg != '0));

        trailer_hit = match_trailer(cfg.trailer_kind, tail_a, tail_b, tail_c);
        eev = cfg.eev_en && ((len <= LEN_W'(prct_pkg::SHORT_LEN)) || trailer_hit);

        off_sum = SUM_W'(offset_reg) + SUM_W'(len);
        off_cmp = CMP_W'(off_sum);
        idx_inc = IDX1_W'(index_reg) + 1'b1;
        wrap = (eev && (off_cmp > CMP_W'(cfg.event_limit))) ||
               (off_cmp > CMP_W'(cfg.buffer_limit)) ||
               (ICMP_W'(idx_inc) >= ICMP_W'(cfg.ring_entries));

        pkts_next  = pkts_reg + 1'b1;
        blow_next  = byte_carry ? prct_pkg::BYTES_LOW_W'(byte_sum - prct_pkg::BILLION)
                                : prct_pkg::BYTES_LOW_W'(byte_sum);
        bhigh_next = byte_carry ? bhigh_reg + 1'b1 : bhigh_reg;
        gaps_next  = gap ? gaps_reg + 1'b1 : gaps_reg;
        last_next  = cfg.gap_en ? pkt_counter : last_reg;
        loop_next  = wrap ? loop_reg + 1'b1 : loop_reg;
        index_next = wrap ? '0 : idx_inc[RING_INDEX_BITS-1:0];
        offset_next = wrap ? '0 : off_sum[BUFFER_ADDR_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            index_reg  <= '0;
            loop_reg   <= '0;
            last_reg   <= '0;
            gaps_reg   <= '0;
            pkts_reg   <= '0;
            blow_reg   <= '0;
            bhigh_reg  <= '0;
        end
        else if (clr_en)
        begin
            offset_reg <= '0;
            index_reg  <= '0;
            loop_reg   <= '0;
            last_reg   <= '0;
            gaps_reg   <= '0;
            pkts_reg   <= '0;
            blow_reg   <= '0;
            bhigh_reg  <= '0;
        end
        else if (pkt_en)
        begin
            offset_reg <= offset_next;
            index_reg  <= index_next;
            loop_reg   <= loop_next;
            last_reg   <= last_next;
            gaps_reg   <= gaps_next;
            pkts_reg   <= pkts_next;
            blow_reg   <= blow_next;
            bhigh_reg  <= bhigh_next;
        end
    end

    assign res_status      = loop_reg | (gap ? prct_pkg::STATUS_GAP : '0) |
                             (eev ? prct_pkg::STATUS_EEV : '0);
    assign res_index       = index_reg;
    assign res_length      = len;
    assign res_offset      = offset_reg;
    assign res_next_offset = offset_next;
    assign res_missing     = gaps_next;
    assign res_packets     = pkts_next;
    assign res_bytes_low   = blow_next;
    assign res_bytes_high  = bhigh_next;

endmodule

>>> src/prct_checker.sv
// Port-level checker for the packet ring capture tracker, with its bind
`timescale 1ns / 1ps
`include "packet_ring_capture_tracker_unit_macros.svh"

module prct_checker #(
    parameter int BUFFER_ADDR_BITS = 26,
    parameter int RING_INDEX_BITS  = 16,
    parameter int LENGTH_BITS      = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [RING_INDEX_BITS-1:0]          entry_index,
    input  logic [LENGTH_BITS:0]                entry_length,
    input  logic [BUFFER_ADDR_BITS-1:0]         data_offset,
    input  logic [BUFFER_ADDR_BITS-1:0]         next_offset,
    input  logic [prct_pkg::BYTES_LOW_W-1:0]    bytes_low
);

    `PRCT_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(entry_index) && $stable(next_offset),
        "stalled transaction changed")

    `PRCT_ASSERT_IMP(a_offset_step, out_valid,
        (next_offset == '0) ||
        (next_offset == BUFFER_ADDR_BITS'(data_offset + entry_length)),
        "next offset neither wrapped nor advanced by the length")

    `PRCT_ASSERT_IMP(a_bytes_low_range, out_valid,
        {1'b0, bytes_low} <= prct_pkg::BILLION,
        "byte low total above one billion")

endmodule

bind packet_ring_capture_tracker_unit prct_checker #(
    .BUFFER_ADDR_BITS (BUFFER_ADDR_BITS),
    .RING_INDEX_BITS  (RING_INDEX_BITS),
    .LENGTH_BITS      (LENGTH_BITS)
) u_prct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .entry_index  (entry_index),
    .entry_length (entry_length),
    .data_offset  (data_offset),
    .next_offset  (next_offset),
    .bytes_low    (bytes_low)
);
